@@ sv/bpf_pkg.sv @@
// shared types and codes for the byte pipe fifo
`default_nettype none

package bpf_pkg;

  typedef enum logic [2:0] {
    K_WRITE    = 3'd0,
    K_READ     = 3'd1,
    K_POLL_RD  = 3'd2,
    K_POLL_WR  = 3'd3,
    K_CLOSE_RD = 3'd4,
    K_CLOSE_WR = 3'd5,
    K_OPEN_RD  = 3'd6,
    K_OPEN_WR  = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BLOCK = 2'd1,
    ST_EOF   = 2'd2,
    ST_EPIPE = 2'd3
  } status_e;

endpackage

`default_nettype wire

@@ sv/byte_pipe_fifo_with_end_tracking.sv @@
// byte ring fifo with open read/write end counts, one result beat per command beat
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i/in_ready_o, kind, data, final  | input
//   out     | out_valid_o/out_ready_i, data, status,    | output
//           | poll flags, fill level, final             |
//
// a write, poll, open or close registers its result on acceptance; a successful read
// registers it from the registered read port of the ring ram, while pend_q is set
// in_ready_o is low while read data is on its way and while a result beat
// is held by a stalled consumer
// reset clears positions and fill count and sets both end counts to one;
// ring contents are not cleared, only written bytes are ever read

`default_nettype none

module byte_pipe_fifo_with_end_tracking #(
  parameter int unsigned DEPTH    = 4096,
  parameter int unsigned MAX_ENDS = 15
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [2:0]                 kind_i,
  input  wire logic [7:0]                 data_in_i,
  input  wire logic                       final_req_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [7:0]                      data_out_o,
  output bpf_pkg::status_e                status_o,
  output logic                            poll_in_o,
  output logic                            poll_out_o,
  output logic                            poll_hup_o,
  output logic                            poll_err_o,
  output logic [$clog2(DEPTH+1)-1:0]      fill_level_o,
  output logic                            final_out_o
);

  import bpf_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = $clog2(MAX_ENDS + 1);

  logic [AW-1:0] wpos_q, wpos_d, rpos_q, rpos_d;
  logic [CW-1:0] held_q, held_d;
  logic [EW-1:0] readers_q, readers_d, writers_q, writers_d;
  logic          pend_q, pend_d;
  logic          pend_final_q, pend_final_d;

  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_data_q, out_data_d;
  status_e       out_status_q, out_status_d;
  logic          out_pin_q, out_pin_d, out_pout_q, out_pout_d;
  logic          out_phup_q, out_phup_d, out_perr_q, out_perr_d;
  logic [CW-1:0] out_fill_q, out_fill_d;
  logic          out_final_q, out_final_d;

  logic          ram_we, ram_re;
  logic [7:0]    ram_rdata;
  logic          accept, full;
  logic [EW-1:0] readers_dec, writers_dec;
  kind_e         kind;

  assign kind   = kind_e'(kind_i);
  assign full   = (held_q == CW'(DEPTH));
  assign accept = in_valid_i && in_ready_o;
  assign readers_dec = (readers_q != '0) ? readers_q - EW'(1) : readers_q;
  assign writers_dec = (writers_q != '0) ? writers_q - EW'(1) : writers_q;

  // the output slot must be free (or emptying) so a result has a place when it is registered
  assign in_ready_o = !pend_q && (!out_valid_q || out_ready_i);

  // only one item is in flight around a read, so ram accesses never overlap
  bpf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wpos_q),
    .wdata_i (data_in_i),
    .re_i    (ram_re),
    .raddr_i (rpos_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    wpos_d       = wpos_q;
    rpos_d       = rpos_q;
    held_d       = held_q;
    readers_d    = readers_q;
    writers_d    = writers_q;
    pend_d       = 1'b0;
    pend_final_d = pend_final_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    out_valid_d  = out_valid_q && !out_ready_i;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    out_pin_d    = out_pin_q;
    out_pout_d   = out_pout_q;
    out_phup_d   = out_phup_q;
    out_perr_d   = out_perr_q;
    out_fill_d   = out_fill_q;
    out_final_d  = out_final_q;

    if (pend_q) begin
      out_valid_d  = 1'b1;
      out_data_d   = ram_rdata;
      out_status_d = ST_OK;
      out_pin_d    = 1'b0;
      out_pout_d   = 1'b0;
      out_phup_d   = 1'b0;
      out_perr_d   = 1'b0;
      out_fill_d   = held_q;
      out_final_d  = pend_final_q;
    end

    if (accept) begin
      out_valid_d  = 1'b1;
      out_data_d   = '0;
      out_status_d = ST_OK;
      out_pin_d    = 1'b0;
      out_pout_d   = 1'b0;
      out_phup_d   = 1'b0;
      out_perr_d   = 1'b0;
      out_final_d  = final_req_i;

      case (kind)
        K_WRITE: begin
          if (readers_q == '0) begin
            out_status_d = ST_EPIPE;
          end else if (full) begin
            out_status_d = ST_BLOCK;
          end else begin
            ram_we = 1'b1;
            wpos_d = (wpos_q == AW'(DEPTH - 1)) ? '0 : wpos_q + AW'(1);
            held_d = held_q + CW'(1);
          end
        end
        K_READ: begin
          if (held_q != '0) begin
            // result is registered with the ram data while pend_q is set
            ram_re       = 1'b1;
            rpos_d       = (rpos_q == AW'(DEPTH - 1)) ? '0 : rpos_q + AW'(1);
            held_d       = held_q - CW'(1);
            pend_d       = 1'b1;
            pend_final_d = final_req_i;
            out_valid_d  = 1'b0;
          end else if (writers_q == '0) begin
            out_status_d = ST_EOF;
          end else begin
            out_status_d = ST_BLOCK;
          end
        end
        K_POLL_RD: begin
          out_pin_d  = (held_q != '0) || (writers_q == '0);
          out_phup_d = (held_q == '0) && (writers_q == '0);
        end
        K_POLL_WR: begin
          out_perr_d = (readers_q == '0);
          out_pout_d = (readers_q != '0) && !full;
        end
        K_CLOSE_RD, K_CLOSE_WR: begin
          readers_d = (kind == K_CLOSE_RD) ? readers_dec : readers_q;
          writers_d = (kind == K_CLOSE_WR) ? writers_dec : writers_q;
          // last end of both sides gone: back to the reset state
          if (readers_d == '0 && writers_d == '0) begin
            wpos_d    = '0;
            rpos_d    = '0;
            held_d    = '0;
            readers_d = EW'(1);
            writers_d = EW'(1);
          end
        end
        K_OPEN_RD: begin
          if (readers_q < EW'(MAX_ENDS)) begin
            readers_d = readers_q + EW'(1);
          end
        end
        K_OPEN_WR: begin
          if (writers_q < EW'(MAX_ENDS)) begin
            writers_d = writers_q + EW'(1);
          end
        end
        default: begin
        end
      endcase

      out_fill_d = held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q      <= '0;
      rpos_q      <= '0;
      held_q      <= '0;
      readers_q   <= EW'(1);
      writers_q   <= EW'(1);
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wpos_q      <= wpos_d;
      rpos_q      <= rpos_d;
      held_q      <= held_d;
      readers_q   <= readers_d;
      writers_q   <= writers_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_final_q <= pend_final_d;
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
    out_pin_q    <= out_pin_d;
    out_pout_q   <= out_pout_d;
    out_phup_q   <= out_phup_d;
    out_perr_q   <= out_perr_d;
    out_fill_q   <= out_fill_d;
    out_final_q  <= out_final_d;
  end

  assign out_valid_o  = out_valid_q;
  assign data_out_o   = out_data_q;
  assign status_o     = out_status_q;
  assign poll_in_o    = out_pin_q;
  assign poll_out_o   = out_pout_q;
  assign poll_hup_o   = out_phup_q;
  assign poll_err_o   = out_perr_q;
  assign fill_level_o = out_fill_q;
  assign final_out_o  = out_final_q;

endmodule

`default_nettype wire

@@ sv/bpf_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none

module bpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ sv/bpf_checker.sv @@
// port-level checks for the byte pipe fifo, bound to the top level
`default_nettype none

module bpf_checker #(
  parameter int unsigned DEPTH = 4096
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_ready_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire logic [7:0]            data_out_o,
  input wire logic                  poll_in_o,
  input wire logic                  poll_out_o,
  input wire logic                  poll_hup_o,
  input wire logic [$clog2(DEPTH+1)-1:0] fill_level_o
);

  // a stalled result beat keeps its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_out_o))
    else $error("result beat changed while stalled");

  // no new command is taken while the result slot is blocked
  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result beat stalled");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fill_level_o <= ($clog2(DEPTH+1))'(DEPTH))
    else $error("fill level above depth");

  // hangup implies readable, and the readable and writable flags never share a beat
  a_poll_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!poll_hup_o || poll_in_o) && !(poll_in_o && poll_out_o))
    else $error("inconsistent poll flags");

endmodule

bind byte_pipe_fifo_with_end_tracking bpf_checker #(
  .DEPTH (DEPTH)
) u_bpf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .data_out_o   (data_out_o),
  .poll_in_o    (poll_in_o),
  .poll_out_o   (poll_out_o),
  .poll_hup_o   (poll_hup_o),
  .fill_level_o (fill_level_o)
);

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for the byte pipe fifo with end tracking
`timescale 1ns / 1ps

module testbench;
  import bpf_pkg::*;

  localparam int unsigned DEPTH    = 4096;
  localparam int unsigned MAX_ENDS = 15;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       fin;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  dout;
    status_e     st;
    logic        p_in;
    logic        p_out;
    logic        p_hup;
    logic        p_err;
    logic [12:0] fill;
    logic        fin;
  } result_t;

  typedef struct packed {
    cmd_t    cmd;
    logic    typed;
    result_t exp;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  kind_i;
  logic [7:0]  data_in_i;
  logic        final_req_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  data_out_o;
  status_e     status_o;
  logic        poll_in_o;
  logic        poll_out_o;
  logic        poll_hup_o;
  logic        poll_err_o;
  logic [12:0] fill_level_o;
  logic        final_out_o;

  byte_pipe_fifo_with_end_tracking #(
    .DEPTH    (DEPTH),
    .MAX_ENDS (MAX_ENDS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .data_in_i    (data_in_i),
    .final_req_i  (final_req_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .data_out_o   (data_out_o),
    .status_o     (status_o),
    .poll_in_o    (poll_in_o),
    .poll_out_o   (poll_out_o),
    .poll_hup_o   (poll_hup_o),
    .poll_err_o   (poll_err_o),
    .fill_level_o (fill_level_o),
    .final_out_o  (final_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the pipe
  logic [7:0]  shadow_ring [DEPTH];
  logic [11:0] wr_idx;
  logic [11:0] rd_idx;
  logic [12:0] held_cnt;
  logic [3:0]  rd_open;
  logic [3:0]  wr_open;

  result_t pending_results [$];
  row_t    dir_tab [$];
  int      mismatches = 0;
  int      beats_sent = 0;
  int      snd_idle;
  int      rcv_idle;
  bit      hold_req = 1'b0;

  function automatic void clear_pipe();
    wr_idx   = '0;
    rd_idx   = '0;
    held_cnt = '0;
    rd_open  = 4'd1;
    wr_open  = 4'd1;
  endfunction

  function automatic result_t predict_pipe(cmd_t c);
    result_t r;
    r     = '0;
    r.st  = ST_OK;
    r.fin = c.fin;
    case (c.kind)
      K_WRITE: begin
        if (rd_open == 0) begin
          r.st = ST_EPIPE;
        end else if (held_cnt == DEPTH) begin
          r.st = ST_BLOCK;
        end else begin
          shadow_ring[wr_idx] = c.data;
          wr_idx   = (wr_idx == DEPTH - 1) ? '0 : wr_idx + 1'b1;
          held_cnt = held_cnt + 1'b1;
        end
      end
      K_READ: begin
        if (held_cnt != 0) begin
          r.dout   = shadow_ring[rd_idx];
          rd_idx   = (rd_idx == DEPTH - 1) ? '0 : rd_idx + 1'b1;
          held_cnt = held_cnt - 1'b1;
        end else if (wr_open == 0) begin
          r.st = ST_EOF;
        end else begin
          r.st = ST_BLOCK;
        end
      end
      K_POLL_RD: begin
        r.p_in  = (held_cnt != 0) || (wr_open == 0);
        r.p_hup = (held_cnt == 0) && (wr_open == 0);
      end
      K_POLL_WR: begin
        r.p_err = (rd_open == 0);
        r.p_out = (rd_open != 0) && (held_cnt < DEPTH);
      end
      K_CLOSE_RD, K_CLOSE_WR: begin
        if (c.kind == K_CLOSE_RD && rd_open != 0) rd_open = rd_open - 1'b1;
        if (c.kind == K_CLOSE_WR && wr_open != 0) wr_open = wr_open - 1'b1;
        // last end of both sides gone: back to the reset state
        if (rd_open == 0 && wr_open == 0) clear_pipe();
      end
      K_OPEN_RD: if (rd_open < MAX_ENDS) rd_open = rd_open + 1'b1;
      default:   if (wr_open < MAX_ENDS) wr_open = wr_open + 1'b1;
    endcase
    r.fill = held_cnt;
    return r;
  endfunction

  function automatic row_t mk_row(kind_e k, logic [7:0] d, logic f, logic typed,
                                  status_e st, logic [7:0] dout, logic [3:0] polls,
                                  logic [12:0] fill);
    row_t r;
    r.cmd   = '{kind: k, data: d, fin: f};
    r.typed = typed;
    r.exp   = '{dout: dout, st: st, p_in: polls[3], p_out: polls[2],
                p_hup: polls[1], p_err: polls[0], fill: fill, fin: f};
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge after the beat is taken
  task automatic push_cmd(cmd_t c, logic typed, result_t typed_res);
    int      gap;
    result_t predicted;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < snd_idle) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= c.kind;
    data_in_i   <= c.data;
    final_req_i <= c.fin;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predicted = predict_pipe(c);
    pending_results.push_back(typed ? typed_res : predicted);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_rand(kind_e k);
    cmd_t c;
    c.kind = k;
    c.data = 8'($urandom_range(0, 255));
    c.fin  = 1'($urandom_range(0, 1));
    push_cmd(c, 1'b0, '0);
  endtask

  // mostly read/write traffic with varying bias, some end churn and noise
  task automatic random_phase(int n_beats);
    int   start;
    int   pick;
    int   bias;
    int   r;
    int   cnt;
    bit   side;
    start    = beats_sent;
    hold_req = 1'b1;
    while (beats_sent - start < n_beats) begin
      pick = $urandom_range(0, 99);
      side = 1'($urandom_range(0, 1));
      if (pick < 65) begin
        case ($urandom_range(0, 2))
          0:       bias = 25;
          1:       bias = 50;
          default: bias = 75;
        endcase
        repeat ($urandom_range(10, 60)) begin
          r = $urandom_range(0, 99);
          if (r < bias)    send_rand(K_WRITE);
          else if (r < 85) send_rand(K_READ);
          else if (r < 92) send_rand(K_POLL_RD);
          else             send_rand(K_POLL_WR);
        end
      end else if (pick < 77) begin
        repeat ($urandom_range(2, 6)) begin
          if ($urandom_range(0, 1)) send_rand($urandom_range(0, 1) ? K_OPEN_RD : K_OPEN_WR);
          else send_rand($urandom_range(0, 1) ? K_CLOSE_RD : K_CLOSE_WR);
        end
      end else if (pick < 82) begin
        // run an end count into saturation
        repeat ($urandom_range(14, 18)) send_rand(side ? K_OPEN_RD : K_OPEN_WR);
      end else if (pick < 90) begin
        // drain one side to zero, sometimes one extra close
        cnt = side ? rd_open : wr_open;
        repeat (cnt + $urandom_range(0, 1)) send_rand(side ? K_CLOSE_RD : K_CLOSE_WR);
      end else begin
        repeat ($urandom_range(1, 5)) send_rand(kind_e'($urandom_range(0, 7)));
      end
    end
  endtask

  task automatic check_field(string name, logic [12:0] want, logic [12:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing pending", $time);
      end else begin
        want = pending_results.pop_front();
        check_field("data_out", want.dout, data_out_o);
        check_field("status", want.st, status_o);
        check_field("poll_in", want.p_in, poll_in_o);
        check_field("poll_out", want.p_out, poll_out_o);
        check_field("poll_hup", want.p_hup, poll_hup_o);
        check_field("poll_err", want.p_err, poll_err_o);
        check_field("fill_level", want.fill, fill_level_o);
        check_field("final_out", want.fin, final_out_o);
      end
    end
  end

  // consumer side, with a long hold-off on request so the input stalls
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (250) @(negedge clk_i);
      end
      out_ready_i <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    kind_i      = K_WRITE;
    data_in_i   = 8'h00;
    final_req_i = 1'b0;
    snd_idle    = 8;
    rcv_idle    = 62;
    clear_pipe();

    // polls are {in, out, hup, err}
    dir_tab.push_back(mk_row(K_READ,     8'h00, 1'b1, 1'b1, ST_BLOCK, 8'h00, 4'b0000, 13'd0));
    dir_tab.push_back(mk_row(K_POLL_RD,  8'hFF, 1'b0, 1'b1, ST_OK,    8'h00, 4'b0000, 13'd0));
    dir_tab.push_back(mk_row(K_POLL_WR,  8'h00, 1'b1, 1'b1, ST_OK,    8'h00, 4'b0100, 13'd0));
    dir_tab.push_back(mk_row(K_WRITE,    8'h00, 1'b0, 1'b1, ST_OK,    8'h00, 4'b0000, 13'd1));
    dir_tab.push_back(mk_row(K_WRITE,    8'hFF, 1'b1, 1'b1, ST_OK,    8'h00, 4'b0000, 13'd2));
    dir_tab.push_back(mk_row(K_WRITE,    8'hA5, 1'b0, 1'b1, ST_OK,    8'h00, 4'b0000, 13'd3));
    dir_tab.push_back(mk_row(K_POLL_RD,  8'h5A, 1'b1, 1'b1, ST_OK,    8'h00, 4'b1000, 13'd3));
    dir_tab.push_back(mk_row(K_READ,     8'hFF, 1'b0, 1'b1, ST_OK,    8'h00, 4'b0000, 13'd2));
    dir_tab.push_back(mk_row(K_READ,     8'h00, 1'b1, 1'b1, ST_OK,    8'hFF, 4'b0000, 13'd1));
    dir_tab.push_back(mk_row(K_CLOSE_WR, 8'h11, 1'b0, 1'b1, ST_OK,    8'h00, 4'b0000, 13'd1));
    // writers gone but data still held: readable, no hangup yet
    dir_tab.push_back(mk_row(K_POLL_RD,  8'h22, 1'b1, 1'b1, ST_OK,    8'h00, 4'b1000, 13'd1));
    dir_tab.push_back(mk_row(K_READ,     8'h33, 1'b0, 1'b1, ST_OK,    8'hA5, 4'b0000, 13'd0));
    dir_tab.push_back(mk_row(K_READ,     8'h44, 1'b1, 1'b1, ST_EOF,   8'h00, 4'b0000, 13'd0));
    dir_tab.push_back(mk_row(K_POLL_RD,  8'h55, 1'b0, 1'b1, ST_OK,    8'h00, 4'b1010, 13'd0));
    dir_tab.push_back(mk_row(K_POLL_WR,  8'h66, 1'b1, 1'b1, ST_OK,    8'h00, 4'b0100, 13'd0));
    dir_tab.push_back(mk_row(K_OPEN_WR,  8'h77, 1'b0, 1'b1, ST_OK,    8'h00, 4'b0000, 13'd0));
    dir_tab.push_back(mk_row(K_CLOSE_RD, 8'h88, 1'b1, 1'b1, ST_OK,    8'h00, 4'b0000, 13'd0));
    dir_tab.push_back(mk_row(K_WRITE,    8'h3C, 1'b0, 1'b1, ST_EPIPE, 8'h00, 4'b0000, 13'd0));
    dir_tab.push_back(mk_row(K_POLL_WR,  8'h99, 1'b1, 1'b1, ST_OK,    8'h00, 4'b0001, 13'd0));
    // close on a count already at zero
    dir_tab.push_back(mk_row(K_CLOSE_RD, 8'hAA, 1'b0, 1'b1, ST_OK,    8'h00, 4'b0000, 13'd0));
    dir_tab.push_back(mk_row(K_READ,     8'hBB, 1'b1, 1'b1, ST_BLOCK, 8'h00, 4'b0000, 13'd0));
    // both counts hit zero, pipe starts over with one end each
    dir_tab.push_back(mk_row(K_CLOSE_WR, 8'hCC, 1'b0, 1'b1, ST_OK,    8'h00, 4'b0000, 13'd0));
    dir_tab.push_back(mk_row(K_POLL_WR,  8'hDD, 1'b1, 1'b1, ST_OK,    8'h00, 4'b0100, 13'd0));
    dir_tab.push_back(mk_row(K_WRITE,    8'h5A, 1'b0, 1'b0, ST_OK,    8'h00, 4'b0000, 13'd0));
    dir_tab.push_back(mk_row(K_OPEN_RD,  8'hEE, 1'b1, 1'b0, ST_OK,    8'h00, 4'b0000, 13'd0));

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) push_cmd(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].exp);
    random_phase(470);

    snd_idle = 62;
    rcv_idle = 8;
    random_phase(470);

    snd_idle = 0;
    rcv_idle = 0;
    random_phase(470);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
